@@ hdl/pmfd_pkg.sv @@
// Package of the power meter frame decoder: frame constants, scale factors,
// register indexes, job and divider types, and the back-end state encoding.
// Depends on nothing; all modules but the queue refer to it by scoped names.
package pmfd_pkg;

    // Frame layout.
    localparam int FRAME_BYTES    = 24;
    localparam int WORD_BYTES_END = 20;
    localparam int WORD_W         = 24;
    localparam int NUM_WORDS      = 6;
    localparam int POS_W          = 5;
    localparam logic [7:0] SYNC_BYTE = 8'h5A;

    // Word slots inside a job, in frame order.
    localparam int W_VP = 0;
    localparam int W_V  = 1;
    localparam int W_CP = 2;
    localparam int W_C  = 3;
    localparam int W_PP = 4;
    localparam int W_P  = 5;

    // Output scale factors.
    localparam int VOLT_SCALE  = 100;
    localparam int CURR_SCALE  = 1000;
    localparam int POWER_SCALE = 100;

    // Configuration registers.
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_VOLTAGE_GAIN = 1'd0;
    localparam t_cfg_idx CFG_CURRENT_GAIN = 1'd1;
    localparam logic [WORD_W-1:0] VOLTAGE_GAIN_RESET = 24'd123644;
    localparam logic [WORD_W-1:0] CURRENT_GAIN_RESET = 24'd65536;

    localparam int QUO_W      = 32;
    localparam int DIVIDEND_W = 48;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_job;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        t_word                 divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [1:0] {
        OP_VOLT,
        OP_CURR,
        OP_POWER
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KV,
        ST_KC,
        ST_KP,
        ST_MX,
        ST_PL,
        ST_PH,
        ST_DS,
        ST_DW,
        ST_OUT
    } t_back_state;

    // Which 24-bit word a frame byte belongs to: (pos - 2) / 3 for pos 2..19.
    function automatic logic [2:0] word_index(input logic [POS_W-1:0] pos);
        logic [2:0] idx;
        idx = 3'd0;
        unique case (pos) inside
            [5'd2:5'd4]:   idx = 3'd0;
            [5'd5:5'd7]:   idx = 3'd1;
            [5'd8:5'd10]:  idx = 3'd2;
            [5'd11:5'd13]: idx = 3'd3;
            [5'd14:5'd16]: idx = 3'd4;
            [5'd17:5'd19]: idx = 3'd5;
            default:       idx = 3'd0;
        endcase
        return idx;
    endfunction

endpackage

@@ hdl/pmfd_byte_if.sv @@
// Byte channel of the power meter frame decoder: valid, ready and one byte.
// Depends on nothing.
interface pmfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source(output valid, output byte_in, input ready);
    modport sink(input valid, input byte_in, output ready);
endinterface

@@ hdl/pmfd_result_if.sv @@
// Result channel of the power meter frame decoder: valid, ready and the
// three scaled readings with their zero-divisor flags. Depends on nothing.
interface pmfd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] voltage_centi;
    logic [31:0] current_milli;
    logic [31:0] power_centi;
    logic [2:0]  zero_divisor_flags;

    modport source(output valid, output voltage_centi, output current_milli,
                   output power_centi, output zero_divisor_flags, input ready);
    modport sink(input valid, input voltage_centi, input current_milli,
                 input power_centi, input zero_divisor_flags, output ready);
endinterface

@@ hdl/pmfd_front.sv @@
// Front end of the power meter frame decoder: finds the sync byte, assembles
// the six meter words and pushes a finished frame into the job queue.
// Depends on pmfd_pkg and pmfd_byte_if.
module pmfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmfd_byte_if.sink         i_byte,
    input  logic              i_full,
    output logic              o_push,
    output pmfd_pkg::t_job    o_job
);

    logic                         r_active;
    logic [pmfd_pkg::POS_W-1:0]   r_pos;
    pmfd_pkg::t_job               r_words;
    pmfd_pkg::t_job               n_words;
    logic                         last;
    logic                         accept;
    logic                         in_words;
    logic [2:0]                   idx;

    assign idx      = pmfd_pkg::word_index(r_pos);
    assign in_words = r_active && (r_pos >= 5'd2) &&
                      (r_pos < pmfd_pkg::POS_W'(pmfd_pkg::WORD_BYTES_END));
    assign last     = r_active && (r_pos >= pmfd_pkg::POS_W'(pmfd_pkg::FRAME_BYTES - 1));

    // The final byte of a frame can only be taken when the queue has room.
    assign i_byte.ready = !(last && i_full);
    assign accept       = i_byte.valid && i_byte.ready;

    always_comb begin
        n_words = r_words;
        if (in_words) begin
            n_words[idx] = {r_words[idx][pmfd_pkg::WORD_W-9:0], i_byte.byte_in};
        end
    end

    assign o_push = accept && last;
    assign o_job  = n_words;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (accept) begin
            if (!r_active) begin
                if (i_byte.byte_in == pmfd_pkg::SYNC_BYTE) begin
                    r_active <= 1'b1;
                    r_pos    <= 5'd2;
                end
            end else if (last) begin
                r_active <= 1'b0;
                r_pos    <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_words <= n_words;
        end
    end

`ifndef SYNTHESIS
    a_active_pos : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos >= 5'd2))
        else $error("frame position below first word byte while active");
`endif

endmodule

@@ hdl/pmfd_queue.sv @@
// Short job queue between the front end and the arithmetic back end.
// Depends on nothing; width and depth come from parameters.
module pmfd_queue #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job queue written while full");
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue read while empty");
`endif

endmodule

@@ hdl/pmfd_divider.sv @@
// Iterative unsigned divider of the power meter frame decoder: a 48-bit
// dividend over a 24-bit divisor, one quotient bit per cycle, saturating at
// 2^32-1. Depends on pmfd_pkg.
module pmfd_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pmfd_pkg::t_div_req  i_req,
    output pmfd_pkg::t_div_rsp  o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [4:0]                        r_cnt;
    pmfd_pkg::t_word                   r_rem;
    pmfd_pkg::t_word                   r_div;
    logic [pmfd_pkg::QUO_W-1:0]        r_q;
    logic [pmfd_pkg::WORD_W:0]         trial;
    logic [pmfd_pkg::WORD_W:0]         diff;
    logic                              ge;
    logic [15:0]                       high;

    assign high  = i_req.dividend[pmfd_pkg::DIVIDEND_W-1:pmfd_pkg::QUO_W];
    assign trial = {r_rem, r_q[pmfd_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // A zero divisor or a quotient that cannot fit finishes at once.
                if (i_req.divisor == '0 || {8'd0, high} >= i_req.divisor) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'd31;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.divisor;
            r_rem <= {8'd0, high};
            if (i_req.divisor == '0) begin
                r_q <= '0;
            end else if ({8'd0, high} >= i_req.divisor) begin
                r_q <= '1;
            end else begin
                r_q <= i_req.dividend[pmfd_pkg::QUO_W-1:0];
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff[pmfd_pkg::WORD_W-1:0] : trial[pmfd_pkg::WORD_W-1:0];
            r_q   <= {r_q[pmfd_pkg::QUO_W-2:0], ge};
        end
    end

`ifndef SYNTHESIS
    a_start_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!r_busy && !r_done))
        else $error("divider started while a division is in flight");
`endif

endmodule

@@ hdl/pmfd_back.sv @@
// Arithmetic back end of the power meter frame decoder: scales the words of
// one frame with a shared multiplier and the shared divider, and holds the
// result in an output register. Depends on pmfd_pkg and pmfd_result_if.
module pmfd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  pmfd_pkg::t_job        i_job,
    output logic                  o_pop,
    input  pmfd_pkg::t_word       i_voltage_gain,
    input  pmfd_pkg::t_word       i_current_gain,
    output pmfd_pkg::t_div_req    o_div_req,
    input  pmfd_pkg::t_div_rsp    i_div_rsp,
    pmfd_result_if.source         o_result
);

    pmfd_pkg::t_back_state  r_state;
    pmfd_pkg::t_back_state  n_state;
    pmfd_pkg::t_op          r_op;
    pmfd_pkg::t_job         r_words;
    logic [63:0]            r_prod;
    logic [30:0]            r_kv;
    logic [33:0]            r_kc;
    logic [30:0]            r_kp;
    logic [15:0]            r_ah;
    logic [31:0]            r_lo;
    logic [31:0]            r_vo;
    logic [31:0]            r_co;
    logic                   r_out_valid;
    logic [31:0]            r_out_v;
    logic [31:0]            r_out_c;
    logic [31:0]            r_out_p;
    logic [2:0]             r_out_flags;

    logic [31:0]            mul_a;
    logic [33:0]            mul_b;
    logic [65:0]            prod_w;
    logic                   mul_en;
    logic                   load_out;
    pmfd_pkg::t_word        divisor_sel;

    assign prod_w = mul_a * mul_b;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmfd_pkg::ST_IDLE: if (i_job_valid) n_state = pmfd_pkg::ST_KV;
            pmfd_pkg::ST_KV:   n_state = pmfd_pkg::ST_KC;
            pmfd_pkg::ST_KC:   n_state = pmfd_pkg::ST_KP;
            pmfd_pkg::ST_KP:   n_state = pmfd_pkg::ST_MX;
            pmfd_pkg::ST_MX: begin
                n_state = (r_op == pmfd_pkg::OP_POWER) ? pmfd_pkg::ST_PL : pmfd_pkg::ST_DS;
            end
            pmfd_pkg::ST_PL:   n_state = pmfd_pkg::ST_PH;
            pmfd_pkg::ST_PH:   n_state = pmfd_pkg::ST_DS;
            pmfd_pkg::ST_DS:   n_state = pmfd_pkg::ST_DW;
            pmfd_pkg::ST_DW: begin
                if (i_div_rsp.done) begin
                    n_state = (r_op == pmfd_pkg::OP_POWER) ? pmfd_pkg::ST_OUT
                                                          : pmfd_pkg::ST_MX;
                end
            end
            pmfd_pkg::ST_OUT:  if (!r_out_valid || o_result.ready) n_state = pmfd_pkg::ST_IDLE;
            default:           n_state = pmfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_op)
            pmfd_pkg::OP_VOLT:  divisor_sel = r_words[pmfd_pkg::W_V];
            pmfd_pkg::OP_CURR:  divisor_sel = r_words[pmfd_pkg::W_C];
            pmfd_pkg::OP_POWER: divisor_sel = r_words[pmfd_pkg::W_P];
            default:            divisor_sel = r_words[pmfd_pkg::W_P];
        endcase
    end

    // Outputs of the sequencer: multiplier operands, queue pop, divider start.
    always_comb begin
        mul_a              = '0;
        mul_b              = '0;
        mul_en             = 1'b0;
        o_pop              = 1'b0;
        load_out           = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = r_prod[63:16];
        o_div_req.divisor  = divisor_sel;
        unique case (r_state)
            pmfd_pkg::ST_IDLE: o_pop = i_job_valid;
            pmfd_pkg::ST_KV: begin
                mul_en = 1'b1;
                mul_a  = {8'd0, i_voltage_gain};
                mul_b  = 34'(pmfd_pkg::VOLT_SCALE);
            end
            pmfd_pkg::ST_KC: begin
                mul_en = 1'b1;
                mul_a  = {8'd0, i_current_gain};
                mul_b  = 34'(pmfd_pkg::CURR_SCALE);
            end
            pmfd_pkg::ST_KP: begin
                mul_en = 1'b1;
                mul_a  = {8'd0, i_current_gain};
                mul_b  = 34'(pmfd_pkg::POWER_SCALE);
            end
            pmfd_pkg::ST_MX: begin
                mul_en = 1'b1;
                unique case (r_op)
                    pmfd_pkg::OP_VOLT: begin
                        mul_a = {8'd0, r_words[pmfd_pkg::W_VP]};
                        mul_b = {3'd0, r_kv};
                    end
                    pmfd_pkg::OP_CURR: begin
                        mul_a = {8'd0, r_words[pmfd_pkg::W_CP]};
                        mul_b = r_kc;
                    end
                    default: begin
                        mul_a = {8'd0, r_words[pmfd_pkg::W_PP]};
                        mul_b = {10'd0, i_voltage_gain};
                    end
                endcase
            end
            pmfd_pkg::ST_PL: begin
                mul_en = 1'b1;
                mul_a  = r_prod[31:0];
                mul_b  = {3'd0, r_kp};
            end
            pmfd_pkg::ST_PH: begin
                mul_en = 1'b1;
                mul_a  = {16'd0, r_ah};
                mul_b  = {3'd0, r_kp};
            end
            pmfd_pkg::ST_DS: begin
                o_div_req.start = 1'b1;
                if (r_op == pmfd_pkg::OP_POWER) begin
                    o_div_req.dividend = r_prod[47:0] + {16'd0, r_lo};
                end
            end
            pmfd_pkg::ST_DW:  ;
            pmfd_pkg::ST_OUT: load_out = !r_out_valid || o_result.ready;
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmfd_pkg::ST_IDLE;
            r_op        <= pmfd_pkg::OP_VOLT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_op <= pmfd_pkg::OP_VOLT;
            end else if (r_state == pmfd_pkg::ST_DW && i_div_rsp.done) begin
                unique case (r_op)
                    pmfd_pkg::OP_VOLT: r_op <= pmfd_pkg::OP_CURR;
                    pmfd_pkg::OP_CURR: r_op <= pmfd_pkg::OP_POWER;
                    default:           r_op <= pmfd_pkg::OP_POWER;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_words <= i_job;
        end
        if (mul_en) begin
            r_prod <= prod_w[63:0];
        end
        if (r_state == pmfd_pkg::ST_KC) begin
            r_kv <= r_prod[30:0];
        end
        if (r_state == pmfd_pkg::ST_KP) begin
            r_kc <= r_prod[33:0];
        end
        if (r_state == pmfd_pkg::ST_MX && r_op == pmfd_pkg::OP_VOLT) begin
            r_kp <= r_prod[30:0];
        end
        if (r_state == pmfd_pkg::ST_PL) begin
            r_ah <= r_prod[47:32];
        end
        if (r_state == pmfd_pkg::ST_PH) begin
            r_lo <= r_prod[63:32];
        end
        if (r_state == pmfd_pkg::ST_DW && i_div_rsp.done) begin
            if (r_op == pmfd_pkg::OP_VOLT) begin
                r_vo <= i_div_rsp.quotient;
            end
            if (r_op == pmfd_pkg::OP_CURR) begin
                r_co <= i_div_rsp.quotient;
            end
        end
        if (load_out) begin
            r_out_v     <= r_vo;
            r_out_c     <= r_co;
            // The power quotient finished in the cycle before this state.
            r_out_p     <= i_div_rsp.quotient;
            r_out_flags <= {r_words[pmfd_pkg::W_P] == '0,
                            r_words[pmfd_pkg::W_C] == '0,
                            r_words[pmfd_pkg::W_V] == '0};
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.voltage_centi      = r_out_v;
    assign o_result.current_milli      = r_out_c;
    assign o_result.power_centi        = r_out_p;
    assign o_result.zero_divisor_flags = r_out_flags;

`ifndef SYNTHESIS
    a_done_in_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == pmfd_pkg::ST_DW))
        else $error("division finished outside of the wait state");
`endif

endmodule

@@ hdl/power_meter_frame_decoder.sv @@
// Top level of the power meter frame decoder: configuration registers, front
// end, job queue, arithmetic back end and divider.
// Depends on pmfd_pkg, pmfd_byte_if, pmfd_result_if and all pmfd_ modules.
//
// Usage:
//   Bytes from the metering chip's serial link enter on i_byte, one per
//   valid/ready transaction. A 0x5A byte opens a 24-byte frame whose first
//   byte is the one received before the sync byte; frame bytes 2 to 19 hold
//   six big-endian 24-bit words. For each frame one result
//   transaction leaves on o_result: voltage x100, current x1000, power x100,
//   each floored and saturated to 32 bits, plus a flag per zero divisor.
//   The gains are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Timing:
//   Bytes are taken one per cycle; i_byte.ready drops only on the last byte
//   of a frame while the job queue is full. After the last byte is taken, a
//   result is formed from three gain products and then three divisions on the
//   shared divider, each done at once when it saturates or the divisor is
//   zero and bit by bit otherwise. The divider sets the rate; the queue lets
//   the bytes of later frames in while the back end still works on a frame.
// Reset and stall:
//   Reset empties the queue, drops any partial frame and loads the gain
//   reset values. A stalled receiver holds the result in the output
//   register; the back end finishes the next frame behind it and waits,
//   and the queue then fills before the byte input stalls.
module power_meter_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    pmfd_byte_if.sink              i_byte,
    pmfd_result_if.source          o_result,
    input  logic                   i_cfg_we,
    input  pmfd_pkg::t_cfg_idx     i_cfg_idx,
    input  pmfd_pkg::t_word        i_cfg_data
);

    pmfd_pkg::t_word     r_voltage_gain;
    pmfd_pkg::t_word     r_current_gain;

    logic                push;
    logic                pop;
    logic                full;
    logic                job_valid;
    pmfd_pkg::t_job      push_job;
    pmfd_pkg::t_job      pop_job;
    pmfd_pkg::t_div_req  div_req;
    pmfd_pkg::t_div_rsp  div_rsp;

    // Read live by the datapath: the user writes gains only idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_gain <= pmfd_pkg::VOLTAGE_GAIN_RESET;
            r_current_gain <= pmfd_pkg::CURRENT_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmfd_pkg::CFG_VOLTAGE_GAIN: r_voltage_gain <= i_cfg_data;
                pmfd_pkg::CFG_CURRENT_GAIN: r_current_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pmfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Holds complete frames so the front end keeps taking bytes while the
    // back end is still dividing.
    pmfd_queue #(
        .WIDTH ($bits(pmfd_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (pop_job)
    );

    pmfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (pop_job),
        .o_pop          (pop),
        .i_voltage_gain (r_voltage_gain),
        .i_current_gain (r_current_gain),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .o_result       (o_result)
    );

    pmfd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
